### hw/rtl/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

    // Grid and number format.
    localparam int MAX_COLS      = 128;
    localparam int MAX_ROWS      = 4096;
    localparam int MIN_DIM       = 3;
    localparam int COL_BITS      = 7;
    localparam int ROW_BITS      = 12;
    localparam int ROWS_CFG_BITS = 13;
    localparam int COLS_CFG_BITS = 8;
    localparam int GAIN_BITS     = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int VALUE_BITS    = 32;
    localparam int FRAC_BITS     = 16;

    // Arithmetic widths of the stencil datapath.
    localparam int LAP_BITS     = VALUE_BITS + 4;
    localparam int HI_BITS      = LAP_BITS - FRAC_BITS;
    localparam int PROD_HI_BITS = HI_BITS + GAIN_BITS + 1;
    localparam int PROD_LO_BITS = 2 * FRAC_BITS;
    localparam int RND_BITS     = PROD_LO_BITS + 1 - FRAC_BITS;
    localparam int INC_BITS     = PROD_HI_BITS + 1;
    localparam int SUM_BITS     = INC_BITS + 1;

    // Reset values of the configuration registers.
    localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET = 13'd100;
    localparam logic [COLS_CFG_BITS-1:0] COLS_RESET = 8'd100;
    localparam logic [GAIN_BITS-1:0]     GAIN_RESET = 16'd66;

    // Queue depths.
    localparam int WQ_DEPTH      = 4;
    localparam int WQ_PTR_BITS   = $clog2(WQ_DEPTH);
    localparam int WQ_CNT_BITS   = $clog2(WQ_DEPTH + 1);
    localparam int RQ_DEPTH      = 4;
    localparam int RQ_PTR_BITS   = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_BITS   = $clog2(RQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_GAIN = 2'd2
    } cfg_reg_t;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                has_up;
        logic                has_self;
        logic                interior;
        logic                last_row;
        logic                frame_end;
    } cell_ctrl_t;

    typedef struct packed {
        cell_ctrl_t ctrl;
        value_t     centre;
        value_t     north;
        value_t     south;
        value_t     east;
        value_t     west;
    } work_t;

    typedef struct packed {
        value_t              value;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                run_last;
        logic                frame_end;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/diffusion_stencil_step_core.sv
`timescale 1ns / 1ps
`default_nettype none

// One explicit diffusion step over a grid streamed in raster order, signed Q16.16.
// Each interior cell becomes cell + gain * (N + S + E + W - 4 * cell), rounded to
// nearest and saturated to 32 bits; border cells pass through unchanged. Results
// lag the input by one row: the cell at (r, c) releases the result for (r - 1, c),
// and a cell on the last row also releases itself right after, so the first row of
// a frame yields no results and the last row yields two per cell (run_last marks the
// final one of each cell, frame_end the last cell of the frame). The block takes one
// cell per clock as long as the result side keeps up; on the last row the result
// side, which delivers one result per clock, halves the input rate. The fetch stage
// reads both line buffers in the accept cycle; a cell then passes one fetch stage,
// the work queue and four arithmetic stages on its way to the result queue.
// The line buffers hold no reset value and need no clearing pass: a new frame
// overwrites them before any value is used. Configuration writes are always taken
// (cfg_ready stays high) and must be made only while no cell is in flight; rows and
// columns are clamped to at least three, and to at most 4096 rows and 128 columns.
module diffusion_stencil_step_core
    import dss_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // Input queue side.
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [VALUE_BITS-1:0]    cell_in,

    // Result queue side.
    output logic                          empty,
    input  wire logic                     pop,
    output logic [VALUE_BITS-1:0]         cell_out,
    output logic [ROW_BITS-1:0]           out_row,
    output logic [COL_BITS-1:0]           out_col,
    output logic                          run_last,
    output logic                          frame_end,

    // Configuration write channel.
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [ROWS_CFG_BITS-1:0] rows_used_reg;
    logic [ROWS_CFG_BITS-1:0] rows_used_next;
    logic [COLS_CFG_BITS-1:0] cols_used_reg;
    logic [COLS_CFG_BITS-1:0] cols_used_next;
    logic [GAIN_BITS-1:0]     gain_reg;
    logic [GAIN_BITS-1:0]     gain_next;

    logic                     cfg_write;
    logic [ROWS_CFG_BITS-1:0] rows_raw;
    logic [COLS_CFG_BITS-1:0] cols_raw;

    logic    q_full;
    logic    q_push;
    work_t   q_wr_item;
    logic    q_empty;
    logic    q_pop;
    work_t   q_rd_item;

    logic    out_full;
    logic    out_push;
    result_t out_item;
    result_t head;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign rows_raw  = cfg_data[ROWS_CFG_BITS-1:0];
    assign cols_raw  = cfg_data[COLS_CFG_BITS-1:0];

    // The frame size is stored already clamped to what the line buffers can serve.
    always_comb
    begin
        rows_used_next = rows_used_reg;
        cols_used_next = cols_used_reg;
        gain_next      = gain_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROWS:
                begin
                    if (rows_raw < ROWS_CFG_BITS'(MIN_DIM))
                    begin
                        rows_used_next = ROWS_CFG_BITS'(MIN_DIM);
                    end
                    else if (rows_raw > ROWS_CFG_BITS'(MAX_ROWS))
                    begin
                        rows_used_next = ROWS_CFG_BITS'(MAX_ROWS);
                    end
                    else
                    begin
                        rows_used_next = rows_raw;
                    end
                end
                REG_COLS:
                begin
                    if (cols_raw < COLS_CFG_BITS'(MIN_DIM))
                    begin
                        cols_used_next = COLS_CFG_BITS'(MIN_DIM);
                    end
                    else if (cols_raw > COLS_CFG_BITS'(MAX_COLS))
                    begin
                        cols_used_next = COLS_CFG_BITS'(MAX_COLS);
                    end
                    else
                    begin
                        cols_used_next = cols_raw;
                    end
                end
                REG_GAIN:
                begin
                    gain_next = cfg_data[GAIN_BITS-1:0];
                end
                default:
                begin
                    gain_next = gain_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= ROWS_RESET;
            cols_used_reg <= COLS_RESET;
            gain_reg      <= GAIN_RESET;
        end
        else
        begin
            rows_used_reg <= rows_used_next;
            cols_used_reg <= cols_used_next;
            gain_reg      <= gain_next;
        end
    end

    dss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cell_in   (cell_in),
        .rows_used (rows_used_reg),
        .cols_used (cols_used_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_wr_item)
    );

    dss_work_queue u_work_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rd_item)
    );

    dss_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .gain     (gain_reg),
        .q_empty  (q_empty),
        .q_item   (q_rd_item),
        .q_pop    (q_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_item (out_item)
    );

    dss_result_fifo u_result_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_item),
        .f_full  (out_full),
        .rd_en   (pop),
        .f_empty (empty),
        .rd_data (head)
    );

    assign cell_out  = head.value;
    assign out_row   = head.row;
    assign out_col   = head.col;
    assign run_last  = head.run_last;
    assign frame_end = head.frame_end;

endmodule

`default_nettype wire

### hw/rtl/dss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_front
    import dss_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire value_t                   cell_in,
    input  wire logic [ROWS_CFG_BITS-1:0] rows_used,
    input  wire logic [COLS_CFG_BITS-1:0] cols_used,
    input  wire logic                     q_full,
    output logic                          q_push,
    output work_t                         q_item
);

    logic [ROW_BITS-1:0] row_count_reg;
    logic [ROW_BITS-1:0] row_count_next;
    logic [COL_BITS-1:0] col_count_reg;
    logic [COL_BITS-1:0] col_count_next;
    logic                sel_reg;
    logic                sel_next;

    value_t line_buffer_a [MAX_COLS];
    value_t line_buffer_b [MAX_COLS];

    value_t a_n_reg;
    value_t b_n_reg;
    value_t a_e_reg;
    value_t b_e_reg;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    value_t     s1_cur_reg;
    cell_ctrl_t s1_ctrl_reg;
    logic       s1_sel_reg;
    logic       s1_row_end_reg;

    value_t centre_reg;
    value_t west_reg;

    logic                acc;
    logic                row_end;
    logic                last_row;
    logic                interior;
    logic [COL_BITS-1:0] e_addr;
    cell_ctrl_t          ctrl;
    logic                s1_emits;
    logic                s1_go;
    value_t              north_sel;
    value_t              east_sel;

    always_comb
    begin
        row_end  = (COLS_CFG_BITS'(col_count_reg) + COLS_CFG_BITS'(1)) >= cols_used;
        last_row = (ROWS_CFG_BITS'(row_count_reg) + ROWS_CFG_BITS'(1)) >= rows_used;
        interior = (row_count_reg >= ROW_BITS'(2))
                   && ((ROWS_CFG_BITS'(row_count_reg) + ROWS_CFG_BITS'(1)) <= rows_used)
                   && (col_count_reg != '0)
                   && ((COLS_CFG_BITS'(col_count_reg) + COLS_CFG_BITS'(2)) <= cols_used);
        e_addr   = row_end ? '0 : col_count_reg + COL_BITS'(1);

        ctrl.row       = row_count_reg;
        ctrl.col       = col_count_reg;
        ctrl.has_up    = (row_count_reg != '0);
        ctrl.has_self  = last_row;
        ctrl.interior  = interior;
        ctrl.last_row  = last_row;
        ctrl.frame_end = row_end && last_row;
    end

    // An item that causes no result leaves the fetch stage without using the queue.
    assign s1_emits = s1_ctrl_reg.has_up || s1_ctrl_reg.has_self;
    assign s1_go    = s1_valid_reg && (!s1_emits || !q_full);
    assign full     = s1_valid_reg && !s1_go;
    assign acc      = push && !full;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        sel_next       = sel_reg;
        if (acc)
        begin
            if (row_end)
            begin
                col_count_next = '0;
                sel_next       = !sel_reg;
                row_count_next = last_row ? '0 : row_count_reg + ROW_BITS'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_BITS'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            sel_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            sel_reg       <= sel_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    // Line buffers: the older row is overwritten by the incoming one, read before write.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            if (sel_reg)
            begin
                line_buffer_a[col_count_reg] <= cell_in;
            end
            else
            begin
                line_buffer_b[col_count_reg] <= cell_in;
            end
            a_n_reg <= line_buffer_a[col_count_reg];
            b_n_reg <= line_buffer_b[col_count_reg];
            a_e_reg <= line_buffer_a[e_addr];
            b_e_reg <= line_buffer_b[e_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cur_reg     <= cell_in;
            s1_ctrl_reg    <= ctrl;
            s1_sel_reg     <= sel_reg;
            s1_row_end_reg <= row_end;
        end
    end

    // At a row end the east port fetched column zero of the row just completed,
    // which becomes the centre of the first column of the next row.
    always_comb
    begin
        north_sel = s1_sel_reg ? a_n_reg : b_n_reg;
        if (s1_row_end_reg)
        begin
            east_sel = s1_sel_reg ? a_e_reg : b_e_reg;
        end
        else
        begin
            east_sel = s1_sel_reg ? b_e_reg : a_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            centre_reg <= east_sel;
            west_reg   <= centre_reg;
        end
    end

    always_comb
    begin
        q_push        = s1_valid_reg && s1_emits && !q_full;
        q_item.ctrl   = s1_ctrl_reg;
        q_item.centre = centre_reg;
        q_item.north  = north_sel;
        q_item.south  = s1_cur_reg;
        q_item.east   = east_sel;
        q_item.west   = west_reg;
    end

    a_row_end_wraps_col: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && row_end) |=> (col_count_reg == '0))
        else $error("column counter did not wrap at the end of a row");

    a_frame_end_wraps_row: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && row_end && last_row) |=> (row_count_reg == '0))
        else $error("row counter did not wrap at the end of a frame");

endmodule

`default_nettype wire

### hw/rtl/dss_work_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_work_queue
    import dss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire work_t wr_data,
    output logic       q_full,
    input  wire logic  rd_en,
    output logic       q_empty,
    output work_t      rd_data
);

    work_t                  slots_reg [WQ_DEPTH];
    logic [WQ_PTR_BITS-1:0] wr_ptr_reg;
    logic [WQ_PTR_BITS-1:0] wr_ptr_next;
    logic [WQ_PTR_BITS-1:0] rd_ptr_reg;
    logic [WQ_PTR_BITS-1:0] rd_ptr_next;
    logic [WQ_CNT_BITS-1:0] count_reg;
    logic [WQ_CNT_BITS-1:0] count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign q_full  = (count_reg == WQ_CNT_BITS'(WQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + WQ_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + WQ_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + WQ_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - WQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/dss_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_back
    import dss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [GAIN_BITS-1:0] gain,
    input  wire logic                 q_empty,
    input  wire work_t                q_item,
    output logic                      q_pop,
    input  wire logic                 out_full,
    output logic                      out_push,
    output result_t                   out_item
);

    // Stage 1: Laplacian.
    logic                        b1_valid_reg;
    cell_ctrl_t                  b1_ctrl_reg;
    value_t                      b1_centre_reg;
    value_t                      b1_cur_reg;
    logic signed [LAP_BITS-1:0]  b1_lap_reg;

    // Stage 2: products.
    logic                           b2_valid_reg;
    cell_ctrl_t                     b2_ctrl_reg;
    value_t                         b2_centre_reg;
    value_t                         b2_cur_reg;
    logic signed [PROD_HI_BITS-1:0] b2_prod_hi_reg;
    logic [PROD_LO_BITS-1:0]        b2_prod_lo_reg;

    // Stage 3: rounded increment.
    logic                       b3_valid_reg;
    cell_ctrl_t                 b3_ctrl_reg;
    value_t                     b3_centre_reg;
    value_t                     b3_cur_reg;
    logic signed [INC_BITS-1:0] b3_inc_reg;

    // Stage 4: saturating sum and emission of one or two results.
    logic                       b4_valid_reg;
    cell_ctrl_t                 b4_ctrl_reg;
    value_t                     b4_centre_reg;
    value_t                     b4_cur_reg;
    logic signed [INC_BITS-1:0] b4_inc_reg;
    logic                       up_pend_reg;
    logic                       up_pend_next;
    logic                       self_pend_reg;
    logic                       self_pend_next;

    logic                       b1_ready;
    logic                       b2_ready;
    logic                       b3_ready;
    logic                       b4_ready;
    logic                       b4_go;

    logic signed [LAP_BITS-1:0]     lap;
    logic signed [HI_BITS-1:0]      lap_hi;
    logic [FRAC_BITS-1:0]           lap_lo;
    logic signed [GAIN_BITS:0]      gain_s;
    logic signed [PROD_HI_BITS-1:0] prod_hi;
    logic [PROD_LO_BITS-1:0]        prod_lo;
    logic [PROD_LO_BITS:0]          lo_rounded;
    logic [RND_BITS-1:0]            rnd;
    logic signed [INC_BITS-1:0]     inc;
    logic signed [SUM_BITS-1:0]     sum;
    value_t                         sat;
    logic                           ovf;

    // Ready chain: a stage takes a new item when it is empty or its item moves on.
    assign b4_go    = b4_valid_reg && !out_full && !(up_pend_reg && self_pend_reg);
    assign b4_ready = !b4_valid_reg || b4_go;
    assign b3_ready = !b3_valid_reg || b4_ready;
    assign b2_ready = !b2_valid_reg || b3_ready;
    assign b1_ready = !b1_valid_reg || b2_ready;
    assign q_pop    = !q_empty && b1_ready;

    always_comb
    begin
        lap = LAP_BITS'(q_item.north) + LAP_BITS'(q_item.south)
              + LAP_BITS'(q_item.east) + LAP_BITS'(q_item.west)
              - (LAP_BITS'(q_item.centre) <<< 2);
    end

    always_comb
    begin
        lap_hi  = b1_lap_reg[LAP_BITS-1:FRAC_BITS];
        lap_lo  = b1_lap_reg[FRAC_BITS-1:0];
        gain_s  = {1'b0, gain};
        prod_hi = lap_hi * gain_s;
        prod_lo = PROD_LO_BITS'(lap_lo) * PROD_LO_BITS'(gain);
    end

    // The low part is rounded to nearest with ties upward before it joins the high part.
    always_comb
    begin
        lo_rounded = {1'b0, b2_prod_lo_reg}
                     + {1'b0, PROD_LO_BITS'(1 << (FRAC_BITS - 1))};
        rnd        = lo_rounded[PROD_LO_BITS:FRAC_BITS];
        inc        = {b2_prod_hi_reg[PROD_HI_BITS-1], b2_prod_hi_reg}
                     + INC_BITS'(rnd);
    end

    always_comb
    begin
        sum = {b4_inc_reg[INC_BITS-1], b4_inc_reg}
              + {{(SUM_BITS - VALUE_BITS){b4_centre_reg[VALUE_BITS-1]}}, b4_centre_reg};
        ovf = !((&sum[SUM_BITS-1:VALUE_BITS-1]) || !(|sum[SUM_BITS-1:VALUE_BITS-1]));
        if (!ovf)
        begin
            sat = sum[VALUE_BITS-1:0];
        end
        else if (sum[SUM_BITS-1])
        begin
            sat = {1'b1, {(VALUE_BITS - 1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(VALUE_BITS - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            up_pend_reg   <= 1'b0;
            self_pend_reg <= 1'b0;
        end
        else
        begin
            if (b1_ready)
            begin
                b1_valid_reg <= !q_empty;
            end
            if (b2_ready)
            begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (b3_ready)
            begin
                b3_valid_reg <= b2_valid_reg;
            end
            if (b4_ready)
            begin
                b4_valid_reg <= b3_valid_reg;
            end
            up_pend_reg   <= up_pend_next;
            self_pend_reg <= self_pend_next;
        end
    end

    always_comb
    begin
        up_pend_next   = up_pend_reg;
        self_pend_next = self_pend_reg;
        if (b4_ready && b3_valid_reg)
        begin
            up_pend_next   = b3_ctrl_reg.has_up;
            self_pend_next = b3_ctrl_reg.has_self;
        end
        else if (out_push)
        begin
            if (up_pend_reg)
            begin
                up_pend_next = 1'b0;
            end
            else
            begin
                self_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_ctrl_reg   <= q_item.ctrl;
            b1_centre_reg <= q_item.centre;
            b1_cur_reg    <= q_item.south;
            b1_lap_reg    <= lap;
        end
        if (b2_ready && b1_valid_reg)
        begin
            b2_ctrl_reg    <= b1_ctrl_reg;
            b2_centre_reg  <= b1_centre_reg;
            b2_cur_reg     <= b1_cur_reg;
            b2_prod_hi_reg <= prod_hi;
            b2_prod_lo_reg <= prod_lo;
        end
        if (b3_ready && b2_valid_reg)
        begin
            b3_ctrl_reg   <= b2_ctrl_reg;
            b3_centre_reg <= b2_centre_reg;
            b3_cur_reg    <= b2_cur_reg;
            b3_inc_reg    <= inc;
        end
        if (b4_ready && b3_valid_reg)
        begin
            b4_ctrl_reg   <= b3_ctrl_reg;
            b4_centre_reg <= b3_centre_reg;
            b4_cur_reg    <= b3_cur_reg;
            b4_inc_reg    <= b3_inc_reg;
        end
    end

    // The updated cell of the row above goes first, the cell itself on the last row after it.
    always_comb
    begin
        out_push = b4_valid_reg && !out_full;
        if (up_pend_reg)
        begin
            out_item.value     = b4_ctrl_reg.interior ? sat : b4_centre_reg;
            out_item.row       = b4_ctrl_reg.row - ROW_BITS'(1);
            out_item.col       = b4_ctrl_reg.col;
            out_item.run_last  = !b4_ctrl_reg.last_row;
            out_item.frame_end = 1'b0;
        end
        else
        begin
            out_item.value     = b4_cur_reg;
            out_item.row       = b4_ctrl_reg.row;
            out_item.col       = b4_ctrl_reg.col;
            out_item.run_last  = 1'b1;
            out_item.frame_end = b4_ctrl_reg.frame_end;
        end
    end

    a_b4_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        b4_valid_reg |-> (up_pend_reg || self_pend_reg))
        else $error("emission stage holds an item with nothing left to send");

    a_double_emits_twice: assert property (@(posedge clk) disable iff (!rst_n)
        (b4_valid_reg && up_pend_reg && self_pend_reg && out_push)
        |=> (b4_valid_reg && !up_pend_reg && self_pend_reg))
        else $error("second result of a last-row cell was lost");

endmodule

`default_nettype wire

### hw/rtl/dss_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_result_fifo
    import dss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output logic         f_full,
    input  wire logic    rd_en,
    output logic         f_empty,
    output result_t      rd_data
);

    result_t                slots_reg [RQ_DEPTH];
    logic [RQ_PTR_BITS-1:0] wr_ptr_reg;
    logic [RQ_PTR_BITS-1:0] wr_ptr_next;
    logic [RQ_PTR_BITS-1:0] rd_ptr_reg;
    logic [RQ_PTR_BITS-1:0] rd_ptr_next;
    logic [RQ_CNT_BITS-1:0] count_reg;
    logic [RQ_CNT_BITS-1:0] count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign f_full  = (count_reg == RQ_CNT_BITS'(RQ_DEPTH));
    assign f_empty = (count_reg == '0);
    assign do_wr   = wr_en && !f_full;
    assign do_rd   = rd_en && !f_empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + RQ_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + RQ_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + RQ_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - RQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the streaming five-point diffusion stencil.
//
// Cells are pushed in raster order through the input queue interface. Every
// accepted cell is run through a predictor kept in this file. The predictor
// mirrors the row and column counters, the two line buffers and the three
// configuration registers, and appends the updated cells that this cell
// releases to a queue of expected updates. The result side pops the block's
// output queue and compares every field of each popped update with the
// oldest expected one.
//
// Stimulus runs in phases. Registers are only rewritten once the block has
// gone quiet, which means every expected update has arrived and a few more
// cycles have passed for cells that release nothing (the first row of a
// frame). The directed phases cover saturation in both directions, the
// rounding tie on both sides of zero, the largest row count (ended early by
// shrinking the row register mid-frame), and a 128-column row that is cut
// short by shrinking the column register mid-row. After that, random phases
// send whole frames with random sizes and gains, including clamped register
// values.
module tb_top;
    import dss_pkg::*;

    localparam int     DRAIN_CYCLES  = 16;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     QUIET_LIMIT   = 3000;
    localparam value_t VMAX          = 32'sh7FFF_FFFF;
    localparam value_t VMIN          = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     push = 1'b0;
    logic                     full;
    value_t                   cell_in = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [VALUE_BITS-1:0]    cell_out;
    logic [ROW_BITS-1:0]      out_row;
    logic [COL_BITS-1:0]      out_col;
    logic                     run_last;
    logic                     frame_end;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_reg_t                 cfg_index = REG_ROWS;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Cells waiting for the input side, and the updates the grid still owes us.
    value_t  pending_cells[$];
    result_t expected_updates[$];
    int      cells_queued = 0;
    int      cells_taken = 0;
    int      mismatches = 0;

    // Percentage of cycles in which each side sits idle; zero during the calm phase.
    int      idle_pct = 35;

    // The receiver honors each hold request by refusing to pop for a long stretch.
    int      holds_requested = 0;
    int      holds_served = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    // Mirror of the block: registers, raster position and the two line buffers.
    logic [ROWS_CFG_BITS-1:0] rows_reg = ROWS_RESET;
    logic [COLS_CFG_BITS-1:0] cols_reg = COLS_RESET;
    logic [GAIN_BITS-1:0]     gain_reg = GAIN_RESET;
    int unsigned              row_at = 0;
    int unsigned              col_at = 0;
    bit                       flip = 1'b0;
    value_t                   line_rows [2][MAX_COLS];

    diffusion_stencil_step_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cell_in   (cell_in),
        .empty     (empty),
        .pop       (pop),
        .cell_out  (cell_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .run_last  (run_last),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register values outside [3, limit] are clamped by the block.
    function automatic int unsigned used_dim(int unsigned v, int unsigned top);
        return (v < MIN_DIM) ? MIN_DIM : ((v > top) ? top : v);
    endfunction

    // Explicit step for one interior cell. The Laplacian is kept exact in 64 bits;
    // the gain product is split into integer and fraction parts so that the
    // fraction rounds to nearest with ties going up, then the sum saturates.
    function automatic value_t diffused(value_t ctr, value_t n, value_t s,
                                        value_t e, value_t w);
        longint lap;
        longint lo;
        longint inc;
        longint sum;
        lap = longint'(n) + longint'(s) + longint'(e) + longint'(w) - 4 * longint'(ctr);
        lo  = lap & 64'sh0000_0000_0000_FFFF;
        inc = (lap >>> FRAC_BITS) * longint'(gain_reg)
            + ((lo * longint'(gain_reg) + 32768) >>> FRAC_BITS);
        sum = longint'(ctr) + inc;
        if (sum > longint'(VMAX))
            return VMAX;
        if (sum < longint'(VMIN))
            return VMIN;
        return value_t'(sum);
    endfunction

    // Advances the mirrored grid by one input cell. The cell at (r, c) releases
    // the update for (r - 1, c); on the last row it also releases itself.
    task automatic advance_grid(value_t cur);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned r;
        int unsigned c;
        bit          row_end;
        bit          last_row;
        value_t      centre;
        value_t      v;
        result_t     upd;
        nrows    = used_dim(rows_reg, MAX_ROWS);
        ncols    = used_dim(cols_reg, MAX_COLS);
        r        = row_at;
        c        = col_at % MAX_COLS;
        // A counter at or past a shrunken limit still ends the row or the frame.
        row_end  = (c + 1 >= ncols);
        last_row = (r + 1 >= nrows);
        if (r >= 1)
        begin
            centre = line_rows[flip][c];
            v      = centre;
            // Only cells with all four neighbors inside the grid are diffused.
            if (r >= 2 && r + 1 <= nrows && c >= 1 && c + 2 <= ncols)
                v = diffused(centre, line_rows[!flip][c], cur,
                             line_rows[flip][(c + 1) % MAX_COLS], line_rows[flip][c - 1]);
            upd.value     = v;
            upd.row       = ROW_BITS'(r - 1);
            upd.col       = COL_BITS'(c);
            upd.run_last  = !last_row;
            upd.frame_end = 1'b0;
            expected_updates.push_back(upd);
        end
        if (last_row)
        begin
            upd.value     = cur;
            upd.row       = ROW_BITS'(r);
            upd.col       = COL_BITS'(c);
            upd.run_last  = 1'b1;
            upd.frame_end = row_end;
            expected_updates.push_back(upd);
        end
        // The buffer two rows back is overwritten with the current row.
        line_rows[!flip][c] = cur;
        if (row_end)
        begin
            col_at = 0;
            flip   = !flip;
            row_at = last_row ? 0 : r + 1;
        end
        else
        begin
            col_at = c + 1;
        end
    endtask

    task automatic flag_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Mostly smooth fields so that the stencil does real work, with a share of
    // full-range values and the two extremes to drive saturation.
    function automatic value_t field_value();
        case ($urandom_range(0, 15))
            0:       return VMAX;
            1:       return VMIN;
            2, 3, 4: return value_t'($urandom);
            default: return value_t'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    task automatic queue_value(value_t v);
        pending_cells.push_back(v);
        cells_queued++;
    endtask

    task automatic queue_cells(int n);
        repeat (n) queue_value(field_value());
    endtask

    // Waits until every queued cell has been taken and every expected update has
    // been popped, then lets the pipeline empty out behind cells that released
    // nothing.
    task automatic settle();
        while (cells_taken != cells_queued || expected_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write transaction; the mirror follows once the block has taken it.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROWS: rows_reg = data[ROWS_CFG_BITS-1:0];
            REG_COLS: cols_reg = data[COLS_CFG_BITS-1:0];
            REG_GAIN: gain_reg = data[GAIN_BITS-1:0];
            default:  ;
        endcase
    endtask

    // Input side. A cell that is offered stays on the port until it is taken;
    // the next one is only picked once the current transaction has completed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                advance_grid(cell_in);
                cells_taken++;
            end
            if (!push || !full)
            begin
                if (pending_cells.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    push    <= 1'b1;
                    cell_in <= pending_cells.pop_front();
                end
                else
                begin
                    push    <= 1'b0;
                    cell_in <= value_t'($urandom);
                end
            end
        end
    end

    // Result side. Every popped update is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_updates.size() == 0)
                begin
                    flag_mismatch($sformatf("update for row %0d col %0d with none expected",
                                            out_row, out_col));
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (cell_out !== want.value)
                        flag_mismatch($sformatf("cell (%0d,%0d) value %0h, expected %0h",
                                                want.row, want.col, cell_out, want.value));
                    if (out_row !== want.row)
                        flag_mismatch($sformatf("row %0d, expected %0d", out_row, want.row));
                    if (out_col !== want.col)
                        flag_mismatch($sformatf("col %0d, expected %0d", out_col, want.col));
                    if (run_last !== want.run_last)
                        flag_mismatch($sformatf("cell (%0d,%0d) run_last %b, expected %b",
                                                want.row, want.col, run_last, want.run_last));
                    if (frame_end !== want.frame_end)
                        flag_mismatch($sformatf("cell (%0d,%0d) frame_end %b, expected %b",
                                                want.row, want.col, frame_end, want.frame_end));
                end
            end
            if (holds_served != holds_requested)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // Ends the run when no transaction of any kind has completed for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        value_t          sat_frame [15];
        value_t          tie_frame [12];
        int              phase;
        int unsigned     rows_val;
        int unsigned     cols_val;
        int unsigned     frames;
        int unsigned     frame_len;
        int unsigned     split;
        logic [GAIN_BITS-1:0] gain_val;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest height, full gain: the cell at (1,1) is pulled far above the
        // top of the range and the cell at (1,3) far below the bottom.
        write_reg(REG_ROWS, 16'd3);
        write_reg(REG_COLS, 16'd5);
        write_reg(REG_GAIN, 16'hFFFF);
        sat_frame = '{32'sd0, VMAX, VMAX, VMIN, 32'sd0,
                      VMAX, VMIN, VMAX, VMAX, VMIN,
                      32'sd0, VMAX, VMIN, VMIN, 32'sd0};
        foreach (sat_frame[i])
            queue_value(sat_frame[i]);
        settle();

        // Gain of one half on a Laplacian of +1 and -1: both land exactly on a
        // half step, so the first rounds up to 1 and the second up to 0.
        write_reg(REG_COLS, 16'd4);
        write_reg(REG_GAIN, 16'h8000);
        tie_frame = '{32'sd0, 32'sd1, -32'sd1, 32'sd0,
                      32'sd0, 32'sd0, 32'sd0, 32'sd0,
                      32'sd0, 32'sd0, 32'sd0, 32'sd0};
        foreach (tie_frame[i])
            queue_value(tie_frame[i]);
        settle();

        // Tallest grid, also through its clamped encoding. The frame is ended
        // early by dropping the row count below the current row, which turns
        // the row in progress into the last one.
        write_reg(REG_ROWS, 16'd4096);
        write_reg(REG_GAIN, 16'($urandom_range(0, 65535)));
        queue_cells(16);
        settle();
        write_reg(REG_ROWS, 16'd8191);
        queue_cells(4);
        settle();
        write_reg(REG_ROWS, 16'd2);
        queue_cells(4);
        settle();

        // Widest row through a clamped column count, then the column count is cut
        // in the middle of the second row: the next cell ends that row at once.
        write_reg(REG_ROWS, 16'd4);
        write_reg(REG_COLS, 16'd255);
        queue_cells(133);
        settle();
        write_reg(REG_COLS, 16'd4);
        queue_cells(9);

        // Random phases of whole frames. Phase 1 runs with no idling at all,
        // phase 2 is one full 128-column frame, phase 3 holds the receiver off
        // while cells keep coming, and phase 5 stops the sender mid-frame until
        // everything it has sent so far has come back.
        for (phase = 0; cells_queued < 800 || phase < 6; phase++)
        begin
            settle();
            idle_pct = (phase == 1) ? 0 : 35;
            rows_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            cols_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            frames   = $urandom_range(1, 3);
            if (phase == 2)
            begin
                rows_val = 3;
                cols_val = 128;
                frames   = 1;
            end
            if (phase == 3)
            begin
                rows_val = 6;
                cols_val = 10;
                frames   = 1;
            end
            case ($urandom_range(0, 5))
                0:       gain_val = '0;
                1:       gain_val = '1;
                default: gain_val = 16'($urandom_range(0, 65535));
            endcase
            write_reg(REG_ROWS, 16'(rows_val));
            write_reg(REG_COLS, 16'(cols_val));
            write_reg(REG_GAIN, gain_val);
            frame_len = used_dim(rows_val, MAX_ROWS) * used_dim(cols_val, MAX_COLS);
            if (phase == 3)
                holds_requested++;
            if (phase == 5)
            begin
                split = $urandom_range(1, frame_len - 1);
                queue_cells(split);
                settle();
                queue_cells(frame_len * frames - split);
            end
            else
            begin
                queue_cells(frame_len * frames);
            end
        end

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_front.sv
hw/rtl/dss_work_queue.sv
hw/rtl/dss_back.sv
hw/rtl/dss_result_fifo.sv
hw/rtl/diffusion_stencil_step_core.sv
tb/tb_top.sv
